>>> rtl/scdec_pkg.sv
`default_nettype none

package scdec_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned KEY_W   = 7;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [CODE_W-1:0] REL_BIT   = 8'h80;
    localparam logic [KEY_W-1:0]  CODE_MASK = 7'h7F;
    localparam logic [KEY_W-1:0]  KEY_LSHIFT = 7'd42;
    localparam logic [KEY_W-1:0]  KEY_RSHIFT = 7'd54;
    localparam logic [KEY_W-1:0]  KEY_CAPS   = 7'd58;

    // Result of classifying one scancode against the current flags.
    typedef struct packed {
        logic              has_result;
        logic [CHAR_W-1:0] ascii_char;
        logic              shift;
        logic              caps;
    } t_xlate;

    // Set-1 key map. The upper flag selects the shifted half of the table.
    function automatic logic [CHAR_W-1:0] key_to_char(
        input logic [KEY_W-1:0] key,
        input logic             upper
    );
        logic [CHAR_W-1:0] ch;
        unique case (key)
            7'd1:  ch = 7'h1B;
            7'd2:  ch = upper ? 7'("!")  : 7'("1");
            7'd3:  ch = upper ? 7'("@")  : 7'("2");
            7'd4:  ch = upper ? 7'("#")  : 7'("3");
            7'd5:  ch = upper ? 7'("$")  : 7'("4");
            7'd6:  ch = upper ? 7'("%")  : 7'("5");
            7'd7:  ch = upper ? 7'("^")  : 7'("6");
            7'd8:  ch = upper ? 7'("&")  : 7'("7");
            7'd9:  ch = upper ? 7'("*")  : 7'("8");
            7'd10: ch = upper ? 7'("(")  : 7'("9");
            7'd11: ch = upper ? 7'(")")  : 7'("0");
            7'd12: ch = upper ? 7'("_")  : 7'("-");
            7'd13: ch = upper ? 7'("+")  : 7'("=");
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = upper ? 7'("Q")  : 7'("q");
            7'd17: ch = upper ? 7'("W")  : 7'("w");
            7'd18: ch = upper ? 7'("E")  : 7'("e");
            7'd19: ch = upper ? 7'("R")  : 7'("r");
            7'd20: ch = upper ? 7'("T")  : 7'("t");
            7'd21: ch = upper ? 7'("Y")  : 7'("y");
            7'd22: ch = upper ? 7'("U")  : 7'("u");
            7'd23: ch = upper ? 7'("I")  : 7'("i");
            7'd24: ch = upper ? 7'("O")  : 7'("o");
            7'd25: ch = upper ? 7'("P")  : 7'("p");
            7'd26: ch = upper ? 7'("{")  : 7'("[");
            7'd27: ch = upper ? 7'("}")  : 7'("]");
            7'd28: ch = 7'h0A;
            7'd30: ch = upper ? 7'("A")  : 7'("a");
            7'd31: ch = upper ? 7'("S")  : 7'("s");
            7'd32: ch = upper ? 7'("D")  : 7'("d");
            7'd33: ch = upper ? 7'("F")  : 7'("f");
            7'd34: ch = upper ? 7'("G")  : 7'("g");
            7'd35: ch = upper ? 7'("H")  : 7'("h");
            7'd36: ch = upper ? 7'("J")  : 7'("j");
            7'd37: ch = upper ? 7'("K")  : 7'("k");
            7'd38: ch = upper ? 7'("L")  : 7'("l");
            7'd39: ch = upper ? 7'(":")  : 7'(";");
            7'd40: ch = upper ? 7'("\"") : 7'("'");
            7'd41: ch = upper ? 7'("~")  : 7'h60;
            7'd43: ch = 7'("\\");
            7'd44: ch = upper ? 7'("Z")  : 7'("z");
            7'd45: ch = upper ? 7'("X")  : 7'("x");
            7'd46: ch = upper ? 7'("C")  : 7'("c");
            7'd47: ch = upper ? 7'("V")  : 7'("v");
            7'd48: ch = upper ? 7'("B")  : 7'("b");
            7'd49: ch = upper ? 7'("N")  : 7'("n");
            7'd50: ch = upper ? 7'("M")  : 7'("m");
            7'd51: ch = upper ? 7'("<")  : 7'(",");
            7'd52: ch = upper ? 7'(">")  : 7'(".");
            7'd53: ch = upper ? 7'("?")  : 7'("/");
            7'd55: ch = 7'("*");
            7'd57: ch = 7'(" ");
            7'd74: ch = 7'("-");
            7'd78: ch = 7'("+");
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/scdec_keystate.sv
`default_nettype none

module scdec_keystate (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_advance,
    input  wire logic [scdec_pkg::CODE_W-1:0]   i_code,
    output scdec_pkg::t_xlate                   o_xlate
);

    logic r_shift;
    logic r_caps;
    logic n_shift;
    logic n_caps;

    logic                         is_release;
    logic [scdec_pkg::KEY_W-1:0]  key;
    logic                         is_shift_key;
    logic                         is_caps_key;

    assign is_release   = (i_code & scdec_pkg::REL_BIT) != '0;
    assign key          = i_code[scdec_pkg::KEY_W-1:0] & scdec_pkg::CODE_MASK;
    assign is_shift_key = (key == scdec_pkg::KEY_LSHIFT) || (key == scdec_pkg::KEY_RSHIFT);
    assign is_caps_key  = (key == scdec_pkg::KEY_CAPS);

    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        if (i_advance) begin
            if (is_shift_key) begin
                n_shift = !is_release;
            end else if (is_caps_key && !is_release) begin
                n_caps = !r_caps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

    // A character press leaves the flags alone, so the current flags are
    // also the flags after this step.
    always_comb begin
        o_xlate.has_result = !is_release && !is_shift_key && !is_caps_key;
        o_xlate.ascii_char = scdec_pkg::key_to_char(key, r_shift || r_caps);
        o_xlate.shift      = r_shift;
        o_xlate.caps       = r_caps;
    end

    a_shift_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !is_release && is_shift_key |=> r_shift)
        else $error("shift press did not set the shift flag");

    a_shift_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && is_release && is_shift_key |=> !r_shift)
        else $error("shift release did not clear the shift flag");

    a_caps_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !is_release && is_caps_key |=> r_caps != $past(r_caps))
        else $error("caps lock press did not toggle the flag");

    a_char_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_xlate.has_result |=> $stable(r_shift) && $stable(r_caps))
        else $error("character press changed a flag");

endmodule

`default_nettype wire

>>> rtl/scancode_to_ascii_decoder.sv
// Set-1 keyboard scancode to ASCII decoder.
//
// Input channel: i_valid / o_stall with i_scan_code. One scancode byte per
// transfer. Output channel: o_valid / i_stall with o_ascii_char,
// o_shift_active and o_caps_active.
//
// Shift presses and releases and caps lock presses only update the flags and
// produce no output transfer; every other release is dropped. Any other press
// yields one output transfer with the mapped character (0 if unmapped) and
// the flag values.
//
// An accepted scancode is held in the input register; flag update and key map
// lookup then write the result into the output register, which drives o_valid.
// Throughput is one scancode per cycle while the output is taken.
// When the receiver stalls, the output register holds its result, the input
// register holds the next scancode, and o_stall rises once both are full.
// Reset clears both flags and empties both registers.
`default_nettype none

module scancode_to_ascii_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire logic [scdec_pkg::CODE_W-1:0]      i_scan_code,
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic [scdec_pkg::CHAR_W-1:0]      o_ascii_char,
    output      logic                              o_shift_active,
    output      logic                              o_caps_active
);

    logic                           r_in_valid;
    logic [scdec_pkg::CODE_W-1:0]   r_in_code;
    logic                           r_out_valid;
    logic [scdec_pkg::CHAR_W-1:0]   r_out_char;
    logic                           r_out_shift;
    logic                           r_out_caps;

    logic              out_free;
    logic              advance;
    logic              in_take;
    scdec_pkg::t_xlate xlate;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    scdec_keystate u_keystate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_code    (r_in_code),
        .o_xlate   (xlate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_scan_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && xlate.has_result) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && xlate.has_result) begin
            r_out_char  <= xlate.ascii_char;
            r_out_shift <= xlate.shift;
            r_out_caps  <= xlate.caps;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ascii_char   = r_out_char;
    assign o_shift_active = r_out_shift;
    assign o_caps_active  = r_out_caps;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out_char))
        else $error("stalled result was lost or changed");

    a_no_advance_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !advance)
        else $error("input register advanced into a full output register");

endmodule

`default_nettype wire
